/* design/cc20_pkg.sv */
`timescale 1ns / 1ps

package cc20_pkg;

  localparam int QUEUE_DEPTH = 4;

  // 10 double rounds, each split into 4 half quarter-round steps
  localparam int HALF_STEPS = 40;
  localparam int STEP_W     = 6;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(HALF_STEPS - 1);

  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;

  localparam logic [31:0] SIGMA0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

  typedef enum logic [2:0] {
    REG_KEY0,
    REG_KEY1,
    REG_KEY2,
    REG_KEY3,
    REG_NONCE_LO,
    REG_NONCE_HI,
    REG_START_CTR
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_ROUND,
    ENG_FEED
  } eng_state_t;

  typedef logic [15:0][31:0] block_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [5:0]  offset;
    logic [31:0] counter;
  } item_t;

  typedef struct packed {
    logic [7:0][31:0] key;
    logic [2:0][31:0] nonce;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [31:0] counter;
    logic        flush;
  } eng_cmd_t;

  typedef struct packed {
    logic        busy;
    logic [31:0] busy_ctr;
    logic        blk_valid;
    logic [31:0] blk_ctr;
  } eng_stat_t;

  // One half of a quarter round on all four columns or diagonals at once.
  // late = 0: rotations 16/12, late = 1: rotations 8/7.
  function automatic block_t half_round(block_t w, logic diag, logic late);
    block_t      r;
    logic [1:0]  sb;
    logic [1:0]  sc;
    logic [1:0]  sd;
    logic [3:0]  ia;
    logic [3:0]  ib;
    logic [3:0]  ic;
    logic [3:0]  id;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    r = w;
    for (int q = 0; q < 4; q++) begin
      sb = 2'(q) + {1'b0, diag};
      sc = 2'(q) + {diag, 1'b0};
      sd = 2'(q) + {diag, diag};
      ia = {2'b00, 2'(q)};
      ib = {2'b01, sb};
      ic = {2'b10, sc};
      id = {2'b11, sd};
      a = w[ia];
      b = w[ib];
      c = w[ic];
      d = w[id];
      a = a + b;
      d = d ^ a;
      d = late ? {d[23:0], d[31:24]} : {d[15:0], d[31:16]};
      c = c + d;
      b = b ^ c;
      b = late ? {b[24:0], b[31:25]} : {b[19:0], b[31:20]};
      r[ia] = a;
      r[ib] = b;
      r[ic] = c;
      r[id] = d;
    end
    return r;
  endfunction

endpackage

/* design/cc20_front.sv */
`timescale 1ns / 1ps

module cc20_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic                in_tuser,
  input  logic                in_tlast,
  input  logic [31:0]         start_counter,
  input  logic                q_full,
  output logic                q_push,
  output cc20_pkg::item_t     q_item
);

  logic [5:0]  off_r;
  logic [5:0]  off_nxt;
  logic [31:0] ctr_r;
  logic [31:0] ctr_nxt;
  logic [5:0]  cur_off;
  logic [31:0] cur_ctr;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // a first-flagged byte restarts the block position
  assign cur_off = in_tuser ? 6'd0 : off_r;
  assign cur_ctr = in_tuser ? start_counter : ctr_r;

  assign q_item.data    = in_tdata;
  assign q_item.last    = in_tlast;
  assign q_item.offset  = cur_off;
  assign q_item.counter = cur_ctr;

  always_comb begin
    off_nxt = off_r;
    ctr_nxt = ctr_r;
    if (q_push) begin
      off_nxt = cur_off + 6'd1;
      ctr_nxt = (cur_off == 6'd63) ? cur_ctr + 32'd1 : cur_ctr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= '0;
      ctr_r <= '0;
    end else begin
      off_r <= off_nxt;
      ctr_r <= ctr_nxt;
    end
  end

endmodule

/* design/cc20_fifo.sv */
`timescale 1ns / 1ps

module cc20_fifo #(
  parameter int Depth = cc20_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  cc20_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output cc20_pkg::item_t head,
  output logic            head_valid
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  cc20_pkg::item_t mem [Depth];

  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r;
  logic [PtrW-1:0] rd_ptr_nxt;
  logic [CntW-1:0] count_r;
  logic [CntW-1:0] count_nxt;

  assign full       = (count_r == CntFull);
  assign head_valid = (count_r != '0);
  assign head       = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + PtrW'(1);
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + CntW'(1);
      2'b01:   count_nxt = count_r - CntW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* design/cc20_core.sv */
`timescale 1ns / 1ps

module cc20_core (
  input  logic                clk,
  input  logic                rst_n,
  input  cc20_pkg::cfg_t      cfg,
  input  cc20_pkg::eng_cmd_t  cmd,
  output cc20_pkg::eng_stat_t stat,
  output cc20_pkg::block_t    blk
);

  cc20_pkg::eng_state_t state_r;
  cc20_pkg::eng_state_t state_nxt;

  logic [cc20_pkg::STEP_W-1:0] step_r;
  logic [cc20_pkg::STEP_W-1:0] step_nxt;
  logic                        blk_valid_r;
  logic                        blk_valid_nxt;

  cc20_pkg::block_t init_r;
  cc20_pkg::block_t init_nxt;
  cc20_pkg::block_t work_r;
  cc20_pkg::block_t blk_r;
  cc20_pkg::block_t sum;

  logic load_en;
  logic round_en;
  logic feed_en;
  logic drop_blk;

  always_comb begin
    init_nxt[0]  = cc20_pkg::SIGMA0;
    init_nxt[1]  = cc20_pkg::SIGMA1;
    init_nxt[2]  = cc20_pkg::SIGMA2;
    init_nxt[3]  = cc20_pkg::SIGMA3;
    for (int i = 0; i < 8; i++) begin
      init_nxt[4 + i] = cfg.key[i];
    end
    init_nxt[12] = cmd.counter;
    for (int i = 0; i < 3; i++) begin
      init_nxt[13 + i] = cfg.nonce[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      sum[i] = work_r[i] + init_r[i];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    if (cmd.flush) begin
      state_nxt = cc20_pkg::ENG_IDLE;
    end else if (cmd.start) begin
      state_nxt = cc20_pkg::ENG_ROUND;
    end else begin
      case (state_r)
        cc20_pkg::ENG_ROUND: begin
          if (step_r == cc20_pkg::LAST_STEP) begin
            state_nxt = cc20_pkg::ENG_FEED;
          end
        end
        cc20_pkg::ENG_FEED: state_nxt = cc20_pkg::ENG_IDLE;
        default:            state_nxt = cc20_pkg::ENG_IDLE;
      endcase
    end
  end

  // outputs
  always_comb begin
    load_en  = cmd.start && !cmd.flush;
    drop_blk = cmd.start || cmd.flush;
    round_en = 1'b0;
    feed_en  = 1'b0;
    case (state_r)
      cc20_pkg::ENG_ROUND: round_en = !drop_blk;
      cc20_pkg::ENG_FEED:  feed_en  = !drop_blk;
      default: begin
        round_en = 1'b0;
        feed_en  = 1'b0;
      end
    endcase
    step_nxt = step_r;
    if (load_en) begin
      step_nxt = '0;
    end else if (round_en) begin
      step_nxt = step_r + cc20_pkg::STEP_W'(1);
    end
    blk_valid_nxt = blk_valid_r;
    if (drop_blk) begin
      blk_valid_nxt = 1'b0;
    end else if (feed_en) begin
      blk_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cc20_pkg::ENG_IDLE;
      step_r      <= '0;
      blk_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      blk_valid_r <= blk_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      init_r <= init_nxt;
      work_r <= init_nxt;
    end else if (round_en) begin
      // step bit 1 picks columns or diagonals, bit 0 the half
      work_r <= cc20_pkg::half_round(work_r, step_r[1], step_r[0]);
    end
    if (feed_en) begin
      blk_r <= sum;
    end
  end

  assign blk            = blk_r;
  assign stat.busy      = (state_r != cc20_pkg::ENG_IDLE);
  assign stat.busy_ctr  = init_r[12];
  assign stat.blk_valid = blk_valid_r;
  assign stat.blk_ctr   = init_r[12];

  a_feed_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cc20_pkg::ENG_FEED && !cmd.start && !cmd.flush)
      |=> (blk_valid_r && state_r == cc20_pkg::ENG_IDLE))
    else $error("block not published after feed-forward");

  a_step_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cc20_pkg::ENG_ROUND && step_r != cc20_pkg::LAST_STEP
      && !cmd.start && !cmd.flush)
      |=> (state_r == cc20_pkg::ENG_ROUND
           && step_r == $past(step_r) + cc20_pkg::STEP_W'(1)))
    else $error("round step did not advance");

  a_flush: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |=> (!blk_valid_r && state_r == cc20_pkg::ENG_IDLE))
    else $error("flush left a block or a run behind");

endmodule

/* design/cc20_back.sv */
`timescale 1ns / 1ps

module cc20_back (
  input  logic                clk,
  input  logic                rst_n,
  input  cc20_pkg::item_t     head,
  input  logic                head_valid,
  output logic                pop,
  input  logic                cfg_wr,
  input  cc20_pkg::eng_stat_t stat,
  input  cc20_pkg::block_t    blk,
  output cc20_pkg::eng_cmd_t  cmd,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,
  output logic                out_tlast
);

  cc20_pkg::block_t cur_r;

  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [7:0]  out_data_r;
  logic        out_last_r;
  logic        out_free;
  logic        at_zero;
  logic        hit;
  logic        running;
  logic [31:0] ks_word;
  logic [31:0] ks_shift;

  assign out_free = !out_valid_r || out_tready;
  assign at_zero  = (head.offset == 6'd0);
  assign hit      = stat.blk_valid && (stat.blk_ctr == head.counter);
  assign running  = stat.busy && (stat.busy_ctr == head.counter);
  assign pop      = head_valid && out_free && (!at_zero || hit);

  // first byte of a block comes straight from the engine output
  assign ks_word  = at_zero ? blk[0] : cur_r[head.offset[5:2]];
  assign ks_shift = ks_word >> {head.offset[1:0], 3'b000};

  // on a hit the engine moves on to the next counter value when the byte is popped
  always_comb begin
    cmd.flush   = cfg_wr;
    cmd.start   = 1'b0;
    cmd.counter = head.counter;
    if (head_valid && at_zero) begin
      if (hit) begin
        cmd.start   = out_free;
        cmd.counter = head.counter + 32'd1;
      end else begin
        cmd.start = !running;
      end
    end
    out_valid_nxt = out_free ? pop : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= head.data ^ ks_shift[7:0];
      out_last_r <= head.last;
      if (at_zero) begin
        cur_r <= blk;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_prefetch: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && at_zero && !cfg_wr) |=> stat.busy)
    else $error("no prefetch after block start");

  a_miss_work: assert property (@(posedge clk) disable iff (!rst_n)
    (head_valid && at_zero && !hit && !cfg_wr) |=> (stat.busy || stat.blk_valid))
    else $error("waiting block start without engine activity");

endmodule

/* design/chacha20_stream_cipher.sv */
`timescale 1ns / 1ps

// Channel   Direction  Transfer on               Payload
// in_*      sink       in_tvalid & in_tready     tdata: data_in, tuser: first, tlast: last
// out_*     source     out_tvalid & out_tready   tdata: data_out, tlast: last_out
// cfg_*     APB slave  psel&penable&pwrite       key, nonce, start counter (64-bit data)
//
// Steady state: one byte per cycle while the output is not stalled; the next block is
// prefetched while the current one streams out. A block the engine does not have
// ready (first byte after reset, a first flag, a config write) takes one load, 40 half
// quarter-round steps in the round engine and one feed-forward add.
// Reset (rst_n low, synchronous) clears position and counter to zero.
// Input and output stall independently through the queue and output register.

module chacha20_stream_cipher #(
  parameter int QueueDepth = cc20_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] data_in
  input  logic                            in_tuser,   // [0] first
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // [7:0] data_out
  output logic                            out_tlast,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [cc20_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [cc20_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [cc20_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  logic [63:0] key0_r;
  logic [63:0] key1_r;
  logic [63:0] key2_r;
  logic [63:0] key3_r;
  logic [63:0] nonce_lo_r;
  logic [31:0] nonce_hi_r;
  logic [31:0] start_ctr_r;

  logic                 cfg_wr;
  cc20_pkg::cfg_reg_t   cfg_sel;
  cc20_pkg::cfg_t       cfg;

  logic                 q_full;
  logic                 q_push;
  cc20_pkg::item_t      q_item;
  logic                 q_pop;
  cc20_pkg::item_t      q_head;
  logic                 q_head_valid;

  cc20_pkg::eng_cmd_t   eng_cmd;
  cc20_pkg::eng_stat_t  eng_stat;
  cc20_pkg::block_t     eng_blk;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel    = cc20_pkg::cfg_reg_t'(cfg_paddr[5:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r      <= '0;
      key1_r      <= '0;
      key2_r      <= '0;
      key3_r      <= '0;
      nonce_lo_r  <= '0;
      nonce_hi_r  <= '0;
      start_ctr_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_sel)
        cc20_pkg::REG_KEY0:      key0_r      <= cfg_pwdata;
        cc20_pkg::REG_KEY1:      key1_r      <= cfg_pwdata;
        cc20_pkg::REG_KEY2:      key2_r      <= cfg_pwdata;
        cc20_pkg::REG_KEY3:      key3_r      <= cfg_pwdata;
        cc20_pkg::REG_NONCE_LO:  nonce_lo_r  <= cfg_pwdata;
        cc20_pkg::REG_NONCE_HI:  nonce_hi_r  <= cfg_pwdata[31:0];
        cc20_pkg::REG_START_CTR: start_ctr_r <= cfg_pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      cc20_pkg::REG_KEY0:      cfg_prdata = key0_r;
      cc20_pkg::REG_KEY1:      cfg_prdata = key1_r;
      cc20_pkg::REG_KEY2:      cfg_prdata = key2_r;
      cc20_pkg::REG_KEY3:      cfg_prdata = key3_r;
      cc20_pkg::REG_NONCE_LO:  cfg_prdata = nonce_lo_r;
      cc20_pkg::REG_NONCE_HI:  cfg_prdata = {32'd0, nonce_hi_r};
      cc20_pkg::REG_START_CTR: cfg_prdata = {32'd0, start_ctr_r};
      default:                 cfg_prdata = '0;
    endcase
  end

  assign cfg.key   = {key3_r, key2_r, key1_r, key0_r};
  assign cfg.nonce = {nonce_hi_r, nonce_lo_r};

  cc20_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .in_tlast      (in_tlast),
    .start_counter (start_ctr_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (q_item)
  );

  cc20_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_item),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_head_valid)
  );

  cc20_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .cmd   (eng_cmd),
    .stat  (eng_stat),
    .blk   (eng_blk)
  );

  cc20_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_valid (q_head_valid),
    .pop        (q_pop),
    .cfg_wr     (cfg_wr),
    .stat       (eng_stat),
    .blk        (eng_blk),
    .cmd        (eng_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
